### src/stsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsp_pkg
// Shared types, character codes and the digit decoder of the string parser.
// ----------------------------------------------------------------------------
package stsp_pkg;

  localparam int BASE_BITS = 6;
  localparam int CHAR_BITS = 8;
  localparam int ACC_BITS  = 64;
  localparam int OUT_OFFSET_BITS = 16;

  localparam logic [BASE_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_AUTO   = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_ONE    = 6'd1;
  localparam logic [BASE_BITS-1:0] BASE_OCT    = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC    = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX    = 6'd16;
  localparam logic [BASE_BITS-1:0] BASE_MAX    = 6'd36;
  localparam logic [BASE_BITS-1:0] NO_DIGIT    = 6'd36;

  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7a;
  localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5a;
  localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;

  typedef enum logic [2:0] {
    PH_DONE,
    PH_WS,
    PH_SIGNED,
    PH_ZERO,
    PH_XSEEN,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic                   negative;
    logic [BASE_BITS-1:0]   base;
  } ctl_t;

  // Digit value of a character, NO_DIGIT when it is not 0-9, a-z or A-Z.
  function automatic logic [BASE_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] d;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA + 8'd10;
    end else begin
      d = {2'b00, NO_DIGIT};
    end
    return d[BASE_BITS-1:0];
  endfunction

endpackage

### src/string_to_integer_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_integer_parser_top
// Streaming strtol-style parser: one character in per transfer, one value out
// per string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, char_code, start_req) carries one byte
//   per transfer; start_req opens a new string with that byte as its first
//   character. Output channel (out_valid/out_ready, value, end_offset) gives
//   one transfer per string when the NUL or the first non-digit arrives.
//   radix_wr_en/radix_wr_data set the base (0 = detect from prefix); the base
//   is latched when the start character is processed, so write it while idle.
// Timing:
//   An accepted byte lands in the input register; the combinational parse
//   step (compare, then a 64 x 6 multiply-add into the accumulator) updates
//   the parse state and loads the result register. One byte per cycle is
//   sustained while no result waits on out_ready; the accumulator update
//   loop sets that figure.
// Reset:
//   rst clears the channels, sets the base to 10 and leaves the parser
//   waiting for a start; bytes without a start give no result.
// Stall:
//   While a result waits, bytes that produce no result still advance; a byte
//   that would produce a second result holds in the input register, and
//   in_ready drops until out_ready takes the waiting transfer.
// ----------------------------------------------------------------------------
module string_to_integer_parser_top #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   radix_wr_en,
  input  logic [stsp_pkg::BASE_BITS-1:0]         radix_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [stsp_pkg::CHAR_BITS-1:0]         char_code,
  input  logic                                   start_req,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [stsp_pkg::ACC_BITS-1:0]   value,
  output logic [stsp_pkg::OUT_OFFSET_BITS-1:0]   end_offset
);

  // Configured base.
  logic [stsp_pkg::BASE_BITS-1:0]  radix;

  // Input register.
  logic                            inq_valid;
  logic [stsp_pkg::CHAR_BITS-1:0]  inq_char;
  logic                            inq_start;

  // Parse state carried from byte to byte.
  stsp_pkg::ctl_t                  ctl;
  logic [stsp_pkg::ACC_BITS-1:0]   acc;
  logic [OFFSET_BITS-1:0]          cons;

  stsp_pkg::ctl_t                  ctl_next;
  logic [stsp_pkg::ACC_BITS-1:0]   acc_next;
  logic [OFFSET_BITS-1:0]          cons_next;
  logic                            emit;
  logic [stsp_pkg::ACC_BITS-1:0]   res_value;
  logic [OFFSET_BITS-1:0]          res_offset;
  logic [OFFSET_BITS+stsp_pkg::OUT_OFFSET_BITS-1:0] offset_wide;

  logic                            step_fire;
  logic                            out_free;

  stsp_step #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .ctl        (ctl),
    .acc        (acc),
    .cons       (cons),
    .char_code  (inq_char),
    .start_req  (inq_start),
    .radix      (radix),
    .ctl_next   (ctl_next),
    .acc_next   (acc_next),
    .cons_next  (cons_next),
    .emit       (emit),
    .res_value  (res_value),
    .res_offset (res_offset)
  );

  // Result register is free when empty or being drained this cycle.
  assign out_free  = !out_valid || out_ready;
  // Advance the held byte unless it needs the result register and that is full.
  assign step_fire = inq_valid && (!emit || out_free);
  assign in_ready  = !inq_valid || step_fire;

  // Fit the saturating count to the 16-bit result field.
  assign offset_wide = {{stsp_pkg::OUT_OFFSET_BITS{1'b0}}, res_offset};

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= stsp_pkg::RADIX_RESET;
    end else if (radix_wr_en) begin
      radix <= radix_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      inq_valid <= 1'b1;
    end else if (step_fire) begin
      inq_valid <= 1'b0;
    end
  end

  // Hold the byte until the step consumes it.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_char  <= char_code;
      inq_start <= start_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.phase    <= stsp_pkg::PH_DONE;
      ctl.negative <= 1'b0;
      ctl.base     <= '0;
      acc          <= '0;
      cons         <= '0;
    end else if (step_fire) begin
      ctl  <= ctl_next;
      acc  <= acc_next;
      cons <= cons_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result payload on each emitting step.
  always_ff @(posedge clk) begin
    if (step_fire && emit) begin
      value      <= res_value;
      end_offset <= offset_wide[stsp_pkg::OUT_OFFSET_BITS-1:0];
    end
  end

endmodule

### src/stsp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsp_step
// One character step of the parser: next parse state and the result, if any.
// ----------------------------------------------------------------------------
module stsp_step #(
  parameter int OFFSET_BITS = 16
) (
  input  stsp_pkg::ctl_t                       ctl,
  input  logic [stsp_pkg::ACC_BITS-1:0]        acc,
  input  logic [OFFSET_BITS-1:0]               cons,
  input  logic [stsp_pkg::CHAR_BITS-1:0]       char_code,
  input  logic                                 start_req,
  input  logic [stsp_pkg::BASE_BITS-1:0]       radix,
  output stsp_pkg::ctl_t                       ctl_next,
  output logic [stsp_pkg::ACC_BITS-1:0]        acc_next,
  output logic [OFFSET_BITS-1:0]               cons_next,
  output logic                                 emit,
  output logic [stsp_pkg::ACC_BITS-1:0]        res_value,
  output logic [OFFSET_BITS-1:0]               res_offset
);

  localparam logic [OFFSET_BITS-1:0] CONS_MAX = {OFFSET_BITS{1'b1}};

  stsp_pkg::ctl_t                       cur_ctl;
  logic [stsp_pkg::ACC_BITS-1:0]        cur_acc;
  logic [OFFSET_BITS-1:0]               cur_cons;
  logic [OFFSET_BITS-1:0]               cons_inc;
  logic [OFFSET_BITS-1:0]               xoff;
  logic [stsp_pkg::BASE_BITS-1:0]       digit;
  logic [stsp_pkg::BASE_BITS-1:0]       base_sign;
  logic [stsp_pkg::BASE_BITS-1:0]       base_zero;
  logic [stsp_pkg::ACC_BITS-1:0]        prod;
  logic [stsp_pkg::ACC_BITS-1:0]        mag;
  logic bad_base, is_blank, is_sign, is_zero_ch, is_x, base_0_16;
  logic d_lt_base, d_lt_sign, d_lt_zero, d_lt_hex;

  // Start overrides the held state with a fresh string context.
  always_comb begin
    cur_ctl  = ctl;
    cur_acc  = acc;
    cur_cons = cons;
    if (start_req) begin
      cur_ctl.phase    = stsp_pkg::PH_WS;
      cur_ctl.negative = 1'b0;
      cur_ctl.base     = radix;
      cur_acc          = '0;
      cur_cons         = '0;
    end
  end

  assign bad_base   = start_req && (radix == stsp_pkg::BASE_ONE || radix > stsp_pkg::BASE_MAX);
  assign digit      = stsp_pkg::digit_of(char_code);
  assign cons_inc   = (cur_cons == CONS_MAX) ? cur_cons : cur_cons + 1'b1;
  assign xoff       = (cur_cons == CONS_MAX) ? cur_cons : cur_cons - 1'b1;
  assign is_blank   = char_code == stsp_pkg::CH_SPACE || char_code == stsp_pkg::CH_TAB ||
                      char_code == stsp_pkg::CH_LF || char_code == stsp_pkg::CH_CR;
  assign is_sign    = char_code == stsp_pkg::CH_MINUS || char_code == stsp_pkg::CH_PLUS;
  assign is_zero_ch = char_code == stsp_pkg::CH_ZERO;
  assign is_x       = char_code == stsp_pkg::CH_LX || char_code == stsp_pkg::CH_UX;
  assign base_0_16  = cur_ctl.base == stsp_pkg::BASE_AUTO || cur_ctl.base == stsp_pkg::BASE_HEX;
  assign base_sign  = (cur_ctl.base == stsp_pkg::BASE_AUTO) ? stsp_pkg::BASE_DEC : cur_ctl.base;
  assign base_zero  = (cur_ctl.base == stsp_pkg::BASE_AUTO) ? stsp_pkg::BASE_OCT : cur_ctl.base;
  assign d_lt_base  = digit < cur_ctl.base;
  assign d_lt_sign  = digit < base_sign;
  assign d_lt_zero  = digit < base_zero;
  assign d_lt_hex   = digit < stsp_pkg::BASE_HEX;
  assign prod       = cur_acc * stsp_pkg::ACC_BITS'(cur_ctl.base);

  // Next state.
  always_comb begin
    ctl_next  = cur_ctl;
    acc_next  = cur_acc;
    cons_next = cur_cons;
    if (bad_base) begin
      ctl_next.phase = stsp_pkg::PH_DONE;
    end else begin
      unique case (cur_ctl.phase)
        stsp_pkg::PH_WS, stsp_pkg::PH_SIGNED: begin
          if (cur_ctl.phase == stsp_pkg::PH_WS && is_blank) begin
            cons_next = cons_inc;
          end else if (cur_ctl.phase == stsp_pkg::PH_WS && is_sign) begin
            ctl_next.negative = char_code == stsp_pkg::CH_MINUS;
            ctl_next.phase    = stsp_pkg::PH_SIGNED;
            cons_next         = cons_inc;
          end else if (is_zero_ch && base_0_16) begin
            ctl_next.phase = stsp_pkg::PH_ZERO;
            cons_next      = cons_inc;
          end else begin
            ctl_next.base = base_sign;
            if (d_lt_sign) begin
              acc_next       = stsp_pkg::ACC_BITS'(digit);
              cons_next      = cons_inc;
              ctl_next.phase = stsp_pkg::PH_DIGITS;
            end else begin
              ctl_next.phase = stsp_pkg::PH_DONE;
            end
          end
        end
        stsp_pkg::PH_ZERO: begin
          if (is_x) begin
            ctl_next.base  = stsp_pkg::BASE_HEX;
            ctl_next.phase = stsp_pkg::PH_XSEEN;
            cons_next      = cons_inc;
          end else begin
            ctl_next.base = base_zero;
            if (d_lt_zero) begin
              acc_next       = stsp_pkg::ACC_BITS'(digit);
              cons_next      = cons_inc;
              ctl_next.phase = stsp_pkg::PH_DIGITS;
            end else begin
              acc_next       = '0;
              ctl_next.phase = stsp_pkg::PH_DONE;
            end
          end
        end
        stsp_pkg::PH_XSEEN: begin
          if (d_lt_hex) begin
            acc_next       = stsp_pkg::ACC_BITS'(digit);
            cons_next      = cons_inc;
            ctl_next.phase = stsp_pkg::PH_DIGITS;
          end else begin
            ctl_next.phase = stsp_pkg::PH_DONE;
          end
        end
        stsp_pkg::PH_DIGITS: begin
          if (d_lt_base) begin
            acc_next  = prod + stsp_pkg::ACC_BITS'(digit);
            cons_next = cons_inc;
          end else begin
            ctl_next.phase = stsp_pkg::PH_DONE;
          end
        end
        stsp_pkg::PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Result.
  always_comb begin
    emit       = 1'b0;
    mag        = '0;
    res_offset = '0;
    if (bad_base) begin
      emit = 1'b1;
    end else begin
      unique case (cur_ctl.phase)
        stsp_pkg::PH_WS, stsp_pkg::PH_SIGNED: begin
          if (!(cur_ctl.phase == stsp_pkg::PH_WS && (is_blank || is_sign)) &&
              !(is_zero_ch && base_0_16) && !d_lt_sign) begin
            emit = 1'b1;
          end
        end
        stsp_pkg::PH_ZERO: begin
          if (!is_x && !d_lt_zero) begin
            emit       = 1'b1;
            res_offset = cur_cons;
          end
        end
        stsp_pkg::PH_XSEEN: begin
          if (!d_lt_hex) begin
            emit       = 1'b1;
            res_offset = xoff;
          end
        end
        stsp_pkg::PH_DIGITS: begin
          if (!d_lt_base) begin
            emit       = 1'b1;
            mag        = cur_acc;
            res_offset = cur_cons;
          end
        end
        stsp_pkg::PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign res_value = cur_ctl.negative ? (~mag + 1'b1) : mag;

endmodule

### tb/string_to_integer_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_integer_parser_top_tb
// Self-checking bench for the streaming string-to-integer parser. Strings go
// in one byte per transfer under random bursts and gaps. A parser tracker
// in the bench predicts each parsed value and end offset. The output side
// stalls on its own pattern, and every result transfer is compared field
// by field, in order, against the predicted numbers.
// ----------------------------------------------------------------------------
module string_to_integer_parser_top_tb;
  import stsp_pkg::*;

  localparam int OFFSET_BITS   = 16;
  localparam int OFFSET_SAT    = (1 << OFFSET_BITS) - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_CHARS  = 1200;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [ACC_BITS-1:0]        value;
    logic [OUT_OFFSET_BITS-1:0] end_offset;
  } parsed_number_t;

  // DUT ports; every input starts at a known value.
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       radix_wr_en = 1'b0;
  logic [BASE_BITS-1:0]       radix_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CHAR_BITS-1:0]       char_code = '0;
  logic                       start_req = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [ACC_BITS-1:0] value;
  logic [OUT_OFFSET_BITS-1:0] end_offset;

  // Parser tracker: mirrors the radix register and the per-string state.
  logic [BASE_BITS-1:0] radix_shadow = RADIX_RESET;
  phase_t               trk_phase = PH_DONE;
  logic                 trk_negative = 1'b0;
  logic [ACC_BITS-1:0]  trk_acc = '0;
  logic [BASE_BITS-1:0] trk_base = '0;
  int unsigned          trk_consumed = 0;

  parsed_number_t number_q[$];

  int error_count = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int hold_left   = 0;

  string_to_integer_parser_top #(
    .OFFSET_BITS(OFFSET_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .radix_wr_en  (radix_wr_en),
    .radix_wr_data(radix_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .start_req    (start_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .end_offset   (end_offset)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parser tracker
  // --------------------------------------------------------------------------

  // Digit weight of a byte; NO_DIGIT for anything outside 0-9, a-z, A-Z.
  function automatic logic [BASE_BITS-1:0] char_digit(logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] w;
    w = {2'b00, NO_DIGIT};
    if (c >= CH_ZERO && c <= CH_NINE) w = c - CH_ZERO;
    if (c >= CH_LA && c <= CH_LZ)     w = c - CH_LA + 8'd10;
    if (c >= CH_UA && c <= CH_UZ)     w = c - CH_UA + 8'd10;
    return w[BASE_BITS-1:0];
  endfunction

  function automatic bit is_blank(logic [CHAR_BITS-1:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  task automatic count_char();
    if (trk_consumed < OFFSET_SAT) trk_consumed++;
  endtask

  // Close the string: queue its number and wait for the next start.
  task automatic close_string(logic [ACC_BITS-1:0] mag, int unsigned off);
    parsed_number_t n;
    n.value      = trk_negative ? (64'd0 - mag) : mag;
    n.end_offset = off[OUT_OFFSET_BITS-1:0];
    number_q.push_back(n);
    trk_phase = PH_DONE;
  endtask

  task automatic take_digit(logic [BASE_BITS-1:0] d);
    if (d < trk_base) begin
      trk_acc = trk_acc * {58'd0, trk_base} + {58'd0, d};
      count_char();
    end else begin
      close_string(trk_acc, trk_consumed);
    end
  endtask

  // First character after the blanks and the optional sign.
  task automatic take_lead(logic [CHAR_BITS-1:0] c, logic [BASE_BITS-1:0] d);
    if (c == CH_ZERO && (trk_base == BASE_AUTO || trk_base == BASE_HEX)) begin
      count_char();
      trk_phase = PH_ZERO;
    end else begin
      if (trk_base == BASE_AUTO) trk_base = BASE_DEC;
      if (d < trk_base) begin
        trk_acc = {58'd0, d};
        count_char();
        trk_phase = PH_DIGITS;
      end else begin
        close_string('0, 0);
      end
    end
  endtask

  // Advance the tracker by one accepted byte.
  task automatic parse_char(logic [CHAR_BITS-1:0] c, logic s);
    logic [BASE_BITS-1:0] d;
    bit                   skip;
    d    = char_digit(c);
    skip = 1'b0;
    if (s) begin
      trk_phase    = PH_WS;
      trk_negative = 1'b0;
      trk_acc      = '0;
      trk_consumed = 0;
      trk_base     = radix_shadow;
      if (trk_base == BASE_ONE || trk_base > BASE_MAX) begin
        close_string('0, 0);
        skip = 1'b1;
      end
    end
    if (!skip) begin
      case (trk_phase)
        PH_WS: begin
          if (is_blank(c)) begin
            count_char();
          end else if (c == CH_MINUS || c == CH_PLUS) begin
            trk_negative = (c == CH_MINUS);
            count_char();
            trk_phase = PH_SIGNED;
          end else begin
            take_lead(c, d);
          end
        end
        PH_SIGNED: take_lead(c, d);
        PH_ZERO: begin
          if (c == CH_LX || c == CH_UX) begin
            trk_base = BASE_HEX;
            count_char();
            trk_phase = PH_XSEEN;
          end else begin
            if (trk_base == BASE_AUTO) trk_base = BASE_OCT;
            trk_acc   = '0;
            trk_phase = PH_DIGITS;
            take_digit(d);
          end
        end
        PH_XSEEN: begin
          if (d < BASE_HEX) begin
            trk_acc = {58'd0, d};
            count_char();
            trk_phase = PH_DIGITS;
          end else begin
            // Bare prefix: only the '0' counts, unless the count is pinned.
            close_string('0, trk_consumed < OFFSET_SAT ? trk_consumed - 1 : trk_consumed);
          end
        end
        PH_DIGITS: take_digit(d);
        default: ;
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Send one byte. At the end of each burst most often open a gap, then hold
  // valid and payload until the transfer, and advance the tracker at that edge.
  task automatic push_char(logic [CHAR_BITS-1:0] c, logic s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    char_code <= c;
    start_req <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_char(c, s);
    burst_left--;
  endtask

  // Drop valid and hold off until every predicted number has come out and
  // the pipeline has had time to finish a byte that gives no result.
  task automatic drain();
    in_valid <= 1'b0;
    while (number_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_radix(logic [BASE_BITS-1:0] r);
    drain();
    radix_wr_en   <= 1'b1;
    radix_wr_data <= r;
    @(posedge clk);
    radix_wr_en   <= 1'b0;
    radix_shadow = r;
  endtask

  // Send a string opened by a start, then the byte that should stop it.
  task automatic parse_text(string body, logic [CHAR_BITS-1:0] stop);
    for (int i = 0; i < body.len(); i++) push_char(body[i], i == 0);
    push_char(stop, body.len() == 0);
  endtask

  // --------------------------------------------------------------------------
  // Output side: stall on a pattern, check each transfer
  // --------------------------------------------------------------------------

  // Quiet windows with no stalls alternate with windows of random holds.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ((cycle_count % 3000) >= 800 && $urandom_range(0, 4) == 0) begin
      hold_left <= $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    parsed_number_t want;
    if (!rst && out_valid && out_ready) begin
      if (number_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("cycle %0d: unexpected result value %0d end_offset %0d",
                   cycle_count, value, end_offset);
      end else begin
        want = number_q.pop_front();
        if (value !== want.value || end_offset !== want.end_offset) begin
          error_count++;
          if (error_count <= 10)
            $display("cycle %0d: value exp %0d got %0d, end_offset exp %0d got %0d",
                     cycle_count, $signed(want.value), value, want.end_offset, end_offset);
        end
      end
    end
  end

  // Run limit: well above the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("string_to_integer_parser_top_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Base 10 straight out of reset: blanks, signs, empty strings, restarts.
  task automatic test_reset_base();
    push_char("9", 1'b0);           // bytes with no string open
    push_char(8'h00, 1'b0);
    parse_text(" \t\n\r-123", 8'h00);
    parse_text("+9223372036854775807", "x");
    parse_text("-", 8'h00);         // sign with no digits
    parse_text("+ 5", 8'h00);       // blank after the sign ends it
    parse_text("   ", 8'h00);
    parse_text("", 8'h00);
    parse_text("007", 8'h00);
    parse_text("abc", 8'hff);
    push_char("1", 1'b1);           // left open, then restarted
    push_char("2", 1'b0);
    parse_text("34", 8'h00);
  endtask

  // Prefix detection with base 0, and the optional prefix in base 16.
  task automatic test_prefixes();
    set_radix(BASE_AUTO);
    parse_text("0x1F", 8'h00);
    parse_text("-0XfF", "!");
    parse_text("0x", "g");          // bare hex prefix
    parse_text("017", 8'h00);       // octal
    parse_text("08", 8'h00);        // lone zero, 8 is no octal digit
    parse_text("0", 8'h00);
    parse_text(" 42", 8'h00);
    set_radix(BASE_HEX);
    parse_text("0x", 8'h00);
    parse_text("0ff", 8'h00);
    parse_text("DeadBeef", 8'h00);
  endtask

  // Smallest and largest bases, and bases that stop at the first byte.
  task automatic test_base_limits();
    set_radix(6'd2);
    parse_text("-1011", "2");
    set_radix(BASE_MAX);
    parse_text("Zz", 8'h00);
    set_radix(BASE_ONE);
    parse_text("1", 8'h00);
    set_radix(6'd37);
    parse_text("5", 8'h00);
    set_radix(6'd63);
    parse_text(" 7", 8'h00);
  endtask

  // Values past 64 bits wrap with no error.
  task automatic test_wraparound();
    set_radix(BASE_HEX);
    parse_text("ffffffffffffffff", 8'h00);
    parse_text("-8000000000000000", 8'h00);
    parse_text("10000000000000001", 8'h00);
    set_radix(BASE_MAX);
    parse_text("zzzzzzzzzzzzzzzzzzzz", 8'h00);
  endtask

  // A radix write between two bytes of an open string leaves its base alone.
  task automatic test_midstring_radix();
    set_radix(BASE_HEX);
    push_char("1", 1'b1);
    push_char("2", 1'b0);
    set_radix(BASE_DEC);
    push_char("f", 1'b0);
    push_char(8'h00, 1'b0);
    parse_text("f", 8'h00);
  endtask

  function automatic logic [CHAR_BITS-1:0] random_blank();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [CHAR_BITS-1:0] digit_char(int d);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(d - 10);
  endfunction

  function automatic logic [BASE_BITS-1:0] pick_radix();
    case ($urandom_range(0, 9))
      0: return BASE_AUTO;
      1: return 6'd2;
      2: return BASE_OCT;
      3: return BASE_DEC;
      4: return BASE_HEX;
      5: return BASE_MAX;
      6: return BASE_ONE;
      7: return 6'($urandom_range(37, 63));
      default: return 6'($urandom_range(0, 36));
    endcase
  endfunction

  // Build one string: mostly well formed with random content, some noise,
  // some with a byte corrupted, some left open. Return the bytes that count.
  task automatic random_string(output int n);
    logic [CHAR_BITS-1:0] text[$];
    int                   kind;
    int                   base;
    int                   ndig;
    kind = $urandom_range(0, 9);
    base = radix_shadow;
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) text.push_back(random_blank());
      case ($urandom_range(0, 3))
        0: text.push_back(CH_MINUS);
        1: text.push_back(CH_PLUS);
        default: ;
      endcase
      if (base == BASE_ONE || base > BASE_MAX) base = 10;
      ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 26) : $urandom_range(1, 8);
      if (kind == 1) ndig = 0;
      if (radix_shadow == BASE_AUTO) begin
        case ($urandom_range(0, 2))
          0: begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            base = 16;
          end
          1: begin
            text.push_back(CH_ZERO);
            base = 8;
          end
          default: begin
            base = 10;
            if (ndig > 0) begin
              text.push_back(digit_char($urandom_range(1, 9)));
              ndig--;
            end
          end
        endcase
      end else if (radix_shadow == BASE_HEX && $urandom_range(0, 2) == 0) begin
        text.push_back(CH_ZERO);
        text.push_back($urandom_range(0, 1) ? CH_UX : CH_LX);
      end
      repeat (ndig) text.push_back(digit_char($urandom_range(0, base - 1)));
      if (kind == 3) text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      if (kind != 2) begin
        case ($urandom_range(0, 3))
          0: text.push_back(8'($urandom_range(0, 255)));
          1: text.push_back(base < 36 ? digit_char(base) : 8'h2e);
          default: text.push_back(8'h00);
        endcase
      end
    end
    n = text.size();
    foreach (text[i]) push_char(text[i], i == 0);
    // Trailing bytes after the stop do not count; the tracker parses them too.
    if (kind != 2 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic test_random_strings();
    int sent;
    int n;
    sent = 0;
    set_radix(pick_radix());
    while (sent < RANDOM_CHARS) begin
      if ($urandom_range(0, 24) == 0) set_radix(pick_radix());
      else if ($urandom_range(0, 39) == 0) drain();
      random_string(n);
      sent += n;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_base();
    test_prefixes();
    test_base_limits();
    test_wraparound();
    test_midstring_radix();
    test_random_strings();
    drain();
    if (error_count == 0) begin
      $display("string_to_integer_parser_top_tb passed");
    end else begin
      $display("string_to_integer_parser_top_tb failed");
    end
    $finish;
  end

endmodule

### files.f
src/stsp_pkg.sv
src/stsp_step.sv
src/string_to_integer_parser_top.sv
tb/string_to_integer_parser_top_tb.sv
